// ----- hw/rtl/ipv4_receive_filter_core_assert.svh -----
// Assertion macros shared by the receive filter RTL.
// IPV4RF_ASSERT checks a property while reset is released.
// IPV4RF_ASSERT_ALWAYS checks a property on every clock edge.
`ifndef IPV4_RECEIVE_FILTER_CORE_ASSERT_SVH
`define IPV4_RECEIVE_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define IPV4RF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IPV4RF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPV4RF_ASSERT(lbl, clk, rst_n, prop, msg)
`define IPV4RF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/ipv4rf_pkg.sv -----
`timescale 1ns / 1ps

package ipv4rf_pkg;

    // Header field values
    localparam logic [3:0] IP_VERSION    = 4'd4;
    localparam logic [3:0] MIN_IHL_WORDS = 4'd5;
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] BCAST_BYTE    = 8'hFF;

    // Byte offsets inside the header
    localparam logic [15:0] POS_VER_IHL   = 16'd0;
    localparam logic [15:0] POS_LEN_HI    = 16'd2;
    localparam logic [15:0] POS_LEN_LO    = 16'd3;
    localparam logic [15:0] POS_PROTO     = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST  = 16'd15;
    localparam logic [15:0] POS_DST_FIRST = 16'd16;
    localparam logic [15:0] POS_DST_LAST  = 16'd19;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_EMPTY   = 1'b1;

    // Destination match flags: bit 0 local, bit 1 broadcast
    localparam logic [1:0] DEST_MATCH_ALL = 2'b11;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  payload;
        logic        proto_class;
        logic [31:0] src_addr;
        logic        last;
    } t_result;

endpackage

// ----- hw/rtl/ipv4rf_parse.sv -----
`timescale 1ns / 1ps
`include "ipv4_receive_filter_core_assert.svh"

module ipv4rf_parse
    import ipv4rf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          i_proc,
    input  logic [7:0]    i_data,
    input  logic          i_last,
    output t_result       o_res
);

    logic [31:0] r_local;
    logic [15:0] r_pos,     n_pos;
    logic [3:0]  r_words,   n_words;
    logic [15:0] r_len,     n_len;
    logic [7:0]  r_proto,   n_proto;
    logic [31:0] r_src,     n_src;
    logic [1:0]  r_dest,    n_dest;
    logic [15:0] r_cnt,     n_cnt;
    logic        r_dropped, n_dropped;

    logic        drop_now;
    logic [7:0]  local_byte;
    logic [15:0] hlen;
    logic [15:0] limit;
    logic        len_ok;
    logic        hdr_done;
    logic        at_hdr_end;
    logic        in_payload;
    logic        cnt_below;
    logic        cnt_hits;

    always_comb begin
        unique case (r_pos[1:0])
            2'd0:    local_byte = r_local[31:24];
            2'd1:    local_byte = r_local[23:16];
            2'd2:    local_byte = r_local[15:8];
            default: local_byte = r_local[7:0];
        endcase
    end

    assign hlen       = {10'd0, r_words, 2'b00};
    assign len_ok     = r_len >= hlen;
    assign limit      = r_len - hlen;
    assign at_hdr_end = r_pos == (hlen - 16'd1);
    assign in_payload = r_pos >= hlen;
    assign cnt_below  = r_cnt < limit;
    assign cnt_hits   = ({1'b0, r_cnt} + 17'd1) == {1'b0, limit};

    // Header capture and drop decisions
    always_comb begin
        n_words  = r_words;
        n_len    = r_len;
        n_proto  = r_proto;
        n_src    = r_src;
        n_dest   = r_dest;
        drop_now = 1'b0;
        if (r_pos == POS_VER_IHL) begin
            n_words  = i_data[3:0];
            drop_now = (i_data[7:4] != IP_VERSION) || (i_data[3:0] < MIN_IHL_WORDS);
        end else if (r_pos == POS_LEN_HI) begin
            n_len = {i_data, r_len[7:0]};
        end else if (r_pos == POS_LEN_LO) begin
            n_len = {r_len[15:8], i_data};
        end else if (r_pos == POS_PROTO) begin
            n_proto  = i_data;
            drop_now = (i_data != PROTO_ICMP) && (i_data != PROTO_UDP);
        end else if (r_pos >= POS_SRC_FIRST && r_pos <= POS_SRC_LAST) begin
            n_src = {r_src[23:0], i_data};
        end else if (r_pos >= POS_DST_FIRST && r_pos <= POS_DST_LAST) begin
            n_dest = r_dest & {i_data == BCAST_BYTE, i_data == local_byte};
            drop_now = (r_pos == POS_DST_LAST) && (n_dest == 2'b00);
        end
    end

    assign hdr_done = !r_dropped && !drop_now && (r_pos >= POS_DST_LAST);

    // Result and payload count
    always_comb begin
        o_res             = '0;
        o_res.proto_class = r_proto == PROTO_UDP;
        o_res.src_addr    = r_src;
        n_cnt             = r_cnt;
        if (i_proc && hdr_done) begin
            if (at_hdr_end) begin
                o_res.valid = i_last || (len_ok && limit == 16'd0);
                o_res.kind  = KIND_EMPTY;
                o_res.last  = 1'b1;
            end else if (in_payload && (!len_ok || cnt_below)) begin
                o_res.valid   = 1'b1;
                o_res.kind    = KIND_PAYLOAD;
                o_res.payload = i_data;
                o_res.last    = i_last || (len_ok && cnt_hits);
                if (r_cnt != COUNT_MAX) begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
        end
    end

    assign n_dropped = r_dropped || drop_now;
    assign n_pos     = (r_pos == COUNT_MAX) ? r_pos : r_pos + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local <= '0;
        end else if (i_cfg_wr_en) begin
            r_local <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_words   <= '0;
            r_len     <= '0;
            r_proto   <= '0;
            r_src     <= '0;
            r_dest    <= DEST_MATCH_ALL;
            r_cnt     <= '0;
            r_dropped <= 1'b0;
        end else if (i_proc) begin
            if (i_last) begin
                r_pos     <= '0;
                r_words   <= '0;
                r_len     <= '0;
                r_proto   <= '0;
                r_src     <= '0;
                r_dest    <= DEST_MATCH_ALL;
                r_cnt     <= '0;
                r_dropped <= 1'b0;
            end else if (!r_dropped) begin
                r_pos     <= n_pos;
                r_words   <= n_words;
                r_len     <= n_len;
                r_proto   <= n_proto;
                r_src     <= n_src;
                r_dest    <= n_dest;
                r_cnt     <= n_cnt;
                r_dropped <= n_dropped;
            end else begin
                r_pos <= n_pos;
            end
        end
    end

    `IPV4RF_ASSERT(a_last_restarts, i_clk, i_rst_n, i_proc && i_last |=> r_pos == '0 && !r_dropped, "position not cleared after last byte")
    `IPV4RF_ASSERT(a_no_result_when_dropped, i_clk, i_rst_n, r_dropped |-> !o_res.valid, "result from dropped packet")
    `IPV4RF_ASSERT(a_dest_matched, i_clk, i_rst_n, !r_dropped && r_pos > POS_DST_LAST |-> r_dest != 2'b00, "accepted packet without destination match")
    `IPV4RF_ASSERT(a_empty_notice_form, i_clk, i_rst_n, o_res.valid && o_res.kind == KIND_EMPTY |-> o_res.last && o_res.payload == '0, "malformed empty payload notice")

endmodule

// ----- hw/rtl/ipv4_receive_filter_core.sv -----
`timescale 1ns / 1ps
// Path: a byte's s_axis transaction reaches its result's m_axis transaction through
// the input register, then the result register.
// Throughput: one byte per cycle, set by the single-pass header logic between the
// input register and the result register; m_axis backpressure stalls both registers.
// Reset (i_rst_n low, synchronous): empties both registers, clears local address to 0
// and returns the parser to the start of a packet.
`include "ipv4_receive_filter_core_assert.svh"

module ipv4_receive_filter_core
    import ipv4rf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Local address register
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,

    // Packet byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte

    // Payload stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [39:8] source_address
    output logic [1:0]  m_axis_tuser,   // [0] kind, [1] protocol_class
    output logic        m_axis_tlast    // payload_end
);

    // Input register: one byte waiting to be parsed
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // Result register
    logic        r_out_valid;
    logic        r_out_kind;
    logic [7:0]  r_out_payload;
    logic        r_out_proto;
    logic [31:0] r_out_src;
    logic        r_out_last;

    logic    w_adv;     // result register can take a new value this cycle
    logic    w_proc;    // parse the byte in the input register this cycle
    t_result w_res;

    // Advance whenever the result register is empty or being drained. The input
    // register refills in the same cycle it hands its byte over, so bytes flow
    // one per cycle while m_axis keeps up.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Hold payload until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Header tracking, filtering and result generation
    ipv4rf_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_proc        (w_proc),
        .i_data        (r_in_data),
        .i_last        (r_in_last),
        .o_res         (w_res)
    );

    // Bytes that produce no result (header, dropped, past the length) just
    // leave the result register empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out_kind    <= w_res.kind;
            r_out_payload <= w_res.payload;
            r_out_proto   <= w_res.proto_class;
            r_out_src     <= w_res.src_addr;
            r_out_last    <= w_res.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_src, r_out_payload};
    assign m_axis_tuser  = {r_out_proto, r_out_kind};
    assign m_axis_tlast  = r_out_last;

    `IPV4RF_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready |-> r_in_valid && r_out_valid, "input stalled with free space")
    `IPV4RF_ASSERT(a_byte_held_on_stall, i_clk, i_rst_n, r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_data) && $stable(r_in_last), "pending byte lost under stall")
    `IPV4RF_ASSERT(a_result_loaded, i_clk, i_rst_n, w_adv |=> r_out_valid == $past(w_res.valid), "result register missed a parse result")
    `IPV4RF_ASSERT_ALWAYS(a_no_parse_without_byte, i_clk, w_proc |-> r_in_valid, "parse enabled with empty input register")

endmodule
